// ----- rtl/pss_pkg.sv -----
// Package for the periodic sterilize sequencer: item, state and register
// structs, the one-hot phase encoding and the register index codes.
// No dependencies.
`default_nettype none

package pss_pkg;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 56;

  // Register indexes on the configuration port.
  localparam logic [2:0] CFG_SCHEDULE_ENABLE = 3'd0;
  localparam logic [2:0] CFG_START_HOUR      = 3'd1;
  localparam logic [2:0] CFG_START_MINUTE    = 3'd2;
  localparam logic [2:0] CFG_DAYS_PER_CYCLE  = 3'd3;
  localparam logic [2:0] CFG_POWER_ON_DAYS   = 3'd4;
  localparam logic [2:0] CFG_READY_TIMEOUT   = 3'd5;

  localparam logic        RST_SCHEDULE_ENABLE = 1'b0;
  localparam logic [4:0]  RST_START_HOUR      = 5'd2;
  localparam logic [5:0]  RST_START_MINUTE    = 6'd0;
  localparam logic [7:0]  RST_DAYS_PER_CYCLE  = 8'd3;
  localparam logic [7:0]  RST_POWER_ON_DAYS   = 8'd2;
  localparam logic [15:0] RST_READY_TIMEOUT   = 16'd12000;

  // Clock times are compared as hour * 100 + minute.
  localparam logic [11:0] HOUR_WEIGHT = 12'd100;

  // Numeric mode codes as seen on the result channel.
  localparam logic [2:0] MODE_CODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_CODE_PREPARE  = 3'd1;
  localparam logic [2:0] MODE_CODE_PREHEAT  = 3'd2;
  localparam logic [2:0] MODE_CODE_HOT_FILL = 3'd3;
  localparam logic [2:0] MODE_CODE_HOT_WAIT = 3'd4;
  localparam logic [2:0] MODE_CODE_FINISH   = 3'd5;

  typedef enum logic [5:0] {
    MODE_IDLE     = 6'b000001,
    MODE_PREPARE  = 6'b000010,
    MODE_PREHEAT  = 6'b000100,
    MODE_HOT_FILL = 6'b001000,
    MODE_HOT_WAIT = 6'b010000,
    MODE_FINISH   = 6'b100000
  } mode_t;

  typedef struct packed {
    logic        schedule_enable;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [7:0]  days_per_cycle;
    logic [7:0]  power_on_days;
    logic [15:0] ready_timeout;
  } cfg_t;

  typedef struct packed {
    logic       tray_at_throw;
    logic       phase_done;
    logic       first_hot_draw;
    logic [6:0] busy_mask;
    logic       filters_fitted;
    logic       cover_closed;
    logic       sterilize_inhibit;
    logic       setup_done;
    logic [5:0] clock_minute;
    logic [4:0] clock_hour;
  } in_item_t;

  typedef struct packed {
    logic        ice_ir_request;
    logic        warning_beep;
    logic        tray_down;
    logic        door_close;
    logic [31:0] run_ticks;
    logic [7:0]  day_count;
    logic        armed;
    logic        phase_entered;
    logic [2:0]  mode;
  } out_item_t;

  typedef struct packed {
    mode_t       mode;
    logic        start_latched;
    logic        ready_flag;
    logic        minute_seen;
    logic [7:0]  days_counted;
    logic [15:0] ready_wait;
    logic [31:0] active_ticks;
  } seq_state_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] code;
    unique case (m)
      MODE_IDLE:     code = MODE_CODE_IDLE;
      MODE_PREPARE:  code = MODE_CODE_PREPARE;
      MODE_PREHEAT:  code = MODE_CODE_PREHEAT;
      MODE_HOT_FILL: code = MODE_CODE_HOT_FILL;
      MODE_HOT_WAIT: code = MODE_CODE_HOT_WAIT;
      MODE_FINISH:   code = MODE_CODE_FINISH;
      default:       code = MODE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/periodic_sterilize_sequencer_core.sv -----
// Top level of the periodic sterilize sequencer: input register, sequencer
// state, result register. Uses pss_pkg, pss_cfg_regs and pss_step_logic.
//
//   channel  direction  handshake              payload
//   in_      slave      in_tvalid / in_tready  in_tdata[31:0], one tick
//   out_     master     out_tvalid / out_tready out_tdata[55:0], one result
//   cfg_     slave      cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[15:0]
//
// Each tick passes through the input register, then the result register; one
// tick is accepted every cycle unless the result stalls, and the state update
// is a single combinational pass between the input and result registers.
// Reset is synchronous; it clears the sequencer state, the valid flags and
// loads the register reset values. cfg_ready is always high.
// A stalled result holds the input register, and in_tready drops only then.
`default_nettype none

module periodic_sterilize_sequencer_core import pss_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // clock_hour[4:0], clock_minute[10:5], setup_done[11], sterilize_inhibit[12],
  // cover_closed[13], filters_fitted[14], busy_mask[21:15], first_hot_draw[22],
  // phase_done[23], tray_at_throw[24], zero[31:25]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // mode[2:0], phase_entered[3], armed[4], day_count[12:5], run_ticks[44:13],
  // door_close[45], tray_down[46], warning_beep[47], ice_ir_request[48],
  // zero[55:49]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [15:0]            cfg_data
);

  cfg_t       cfg;
  in_item_t   in_r;
  logic       in_valid_r;
  seq_state_t st_r, st_nxt;
  out_item_t  out_r, res;
  logic       out_valid_r;
  logic       advance;

  pss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pss_step_logic u_step (
    .st     (st_r),
    .cfg    (cfg),
    .it     (in_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // A registered tick moves on when the result register is free or drains.
  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(out_item_t)){1'b0}}, out_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_r <= in_tdata[$bits(in_item_t)-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode          <= MODE_IDLE;
      st_r.start_latched <= 1'b0;
      st_r.ready_flag    <= 1'b0;
      st_r.minute_seen   <= 1'b0;
      st_r.days_counted  <= 8'd0;
      st_r.ready_wait    <= 16'd0;
      st_r.active_ticks  <= 32'd0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_mode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r.mode))
    else $error("sequencer mode register is not one-hot");

  a_entered_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.phase_entered |-> out_r.mode != MODE_CODE_IDLE)
    else $error("phase entered while reporting idle");

  a_beep_ends_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.warning_beep |-> out_r.ice_ir_request)
    else $error("warning beep without end of cycle");

  a_door_starts_prepare: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.door_close |=>
      out_r.phase_entered && out_r.mode == MODE_CODE_PREPARE && st_r.start_latched)
    else $error("door close without entering the prepare phase");
`endif

endmodule

`default_nettype wire

// ----- rtl/pss_cfg_regs.sv -----
// Configuration register file of the periodic sterilize sequencer.
// Depends on pss_pkg for the register struct, indexes and reset values.
`default_nettype none

module pss_cfg_regs import pss_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.schedule_enable <= RST_SCHEDULE_ENABLE;
      cfg_r.start_hour      <= RST_START_HOUR;
      cfg_r.start_minute    <= RST_START_MINUTE;
      cfg_r.days_per_cycle  <= RST_DAYS_PER_CYCLE;
      cfg_r.power_on_days   <= RST_POWER_ON_DAYS;
      cfg_r.ready_timeout   <= RST_READY_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      // Writes to unused indexes are accepted and dropped.
      unique case (cfg_index)
        CFG_SCHEDULE_ENABLE: cfg_r.schedule_enable <= cfg_data[0];
        CFG_START_HOUR:      cfg_r.start_hour      <= cfg_data[4:0];
        CFG_START_MINUTE:    cfg_r.start_minute    <= cfg_data[5:0];
        CFG_DAYS_PER_CYCLE:  cfg_r.days_per_cycle  <= cfg_data[7:0];
        CFG_POWER_ON_DAYS:   cfg_r.power_on_days   <= cfg_data[7:0];
        CFG_READY_TIMEOUT:   cfg_r.ready_timeout   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pss_step_logic.sv -----
// One tick of the sterilize sequencer: next state and result from the
// current state, the registered tick and the configuration. Uses pss_pkg.
`default_nettype none

module pss_step_logic import pss_pkg::*; (
  input  wire seq_state_t st,
  input  wire cfg_t       cfg,
  input  wire in_item_t   it,
  output seq_state_t      st_nxt,
  output out_item_t       res
);

  always_comb begin
    mode_t       m;
    logic        latched, rdy, seen, entered, go;
    logic        p_tray, p_ir, p_beep, p_door;
    logic        guards_ok, abort;
    logic [7:0]  days, days_inc;
    logic [15:0] wait_cnt;
    logic [31:0] ticks;
    logic [11:0] now_val, sched_val;

    m        = st.mode;
    latched  = st.start_latched;
    rdy      = st.ready_flag;
    seen     = st.minute_seen;
    days     = st.days_counted;
    wait_cnt = st.ready_wait;
    entered  = 1'b0;
    go       = 1'b0;
    p_tray   = 1'b0;
    p_ir     = 1'b0;
    p_beep   = 1'b0;
    p_door   = 1'b0;
    days_inc = 8'd0;

    guards_ok = !it.sterilize_inhibit && it.cover_closed && it.filters_fitted;
    abort     = !guards_ok;
    now_val   = 12'(it.clock_hour) * HOUR_WEIGHT + 12'(it.clock_minute);
    sched_val = 12'(cfg.start_hour) * HOUR_WEIGHT + 12'(cfg.start_minute);

    // Guard faults end a running cycle; only cover and filter faults beep.
    if (m != MODE_IDLE && abort) begin
      latched = 1'b0;
      m       = MODE_IDLE;
      p_tray  = !it.tray_at_throw;
      p_ir    = 1'b1;
      p_beep  = !it.cover_closed || !it.filters_fitted;
    end

    ticks = (m != MODE_IDLE) ? st.active_ticks + 32'd1 : 32'd0;

    unique case (m)
      MODE_IDLE: begin
        if (!cfg.schedule_enable || !it.setup_done) begin
          rdy      = 1'b0;
          wait_cnt = 16'd0;
          seen     = 1'b0;
          days     = cfg.power_on_days;
        end else begin
          if (now_val == sched_val) begin
            if (!seen) begin
              days_inc = (days == 8'hFF) ? 8'hFF : days + 8'd1;
              seen     = 1'b1;
              days     = (days_inc >= cfg.days_per_cycle) ? cfg.days_per_cycle
                                                          : days_inc;
            end
            if (guards_ok && days >= cfg.days_per_cycle) begin
              rdy = 1'b1;
            end
          end else begin
            seen = 1'b0;
          end
          if (rdy) begin
            if (guards_ok && it.busy_mask == 7'd0 && !it.first_hot_draw) begin
              latched = 1'b1;
              rdy     = 1'b0;
              p_door  = 1'b1;
            end else begin
              wait_cnt = wait_cnt + 16'd1;
              if (wait_cnt >= cfg.ready_timeout) begin
                // The armed cycle gives up; tray and ice IR are requested as at a normal end.
                wait_cnt = 16'd0;
                rdy      = 1'b0;
                latched  = 1'b0;
                p_tray   = p_tray || !it.tray_at_throw;
                p_ir     = 1'b1;
              end
            end
          end else begin
            wait_cnt = 16'd0;
          end
        end
        go = latched;
        if (it.first_hot_draw) begin
          latched = 1'b0;
          rdy     = 1'b0;
          go      = 1'b0;
        end
        if (go) begin
          m       = MODE_PREPARE;
          entered = 1'b1;
        end
      end
      MODE_PREPARE: begin
        if (it.phase_done) begin
          m       = MODE_PREHEAT;
          entered = 1'b1;
        end
      end
      MODE_PREHEAT: begin
        if (it.phase_done) begin
          m       = MODE_HOT_FILL;
          entered = 1'b1;
        end
      end
      MODE_HOT_FILL: begin
        if (it.phase_done) begin
          m       = MODE_HOT_WAIT;
          entered = 1'b1;
        end
      end
      MODE_HOT_WAIT: begin
        if (it.phase_done) begin
          m       = MODE_FINISH;
          entered = 1'b1;
        end
      end
      MODE_FINISH: begin
        if (it.phase_done) begin
          latched = 1'b0;
          m       = MODE_IDLE;
          p_tray  = !it.tray_at_throw;
          p_ir    = 1'b1;
          if (days >= cfg.days_per_cycle) begin
            days = 8'd0;
          end
        end
      end
      default: m = MODE_IDLE;
    endcase

    st_nxt.mode          = m;
    st_nxt.start_latched = latched;
    st_nxt.ready_flag    = rdy;
    st_nxt.minute_seen   = seen;
    st_nxt.days_counted  = days;
    st_nxt.ready_wait    = wait_cnt;
    st_nxt.active_ticks  = ticks;

    res.mode           = mode_code(m);
    res.phase_entered  = entered;
    res.armed          = rdy;
    res.day_count      = days;
    res.run_ticks      = ticks;
    res.door_close     = p_door;
    res.tray_down      = p_tray;
    res.warning_beep   = p_beep;
    res.ice_ir_request = p_ir;
  end

endmodule

`default_nettype wire
